>>> rtl/core/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions of the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;

    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_BYTE_LAST,
        OP_LAST
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
            k = K0;
        else if (t < 7'd40)
            k = K1;
        else if (t < 7'd60)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t < 7'd40)
            f = b ^ c ^ d;
        else if (t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

>>> rtl/core/sha1md_front.sv
// ----------------------------------------------------------------------------
// sha1md_front
// Input stage: registers each transfer, drops idle items, classifies the rest.
// ----------------------------------------------------------------------------
module sha1md_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        msg_byte,
    input  logic              has_byte,
    input  logic              is_last,
    output logic              cmd_valid,
    output sha1md_pkg::cmd_t  cmd,
    input  logic              cmd_ready
);
    import sha1md_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    logic take;
    logic drain;

    assign in_stall  = cmd_valid_reg && !cmd_ready;
    assign take      = in_valid && !in_stall;
    assign drain     = cmd_valid_reg && cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                cmd_valid_reg <= has_byte || is_last;
            else if (drain)
                cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.data <= msg_byte;
            if (has_byte && is_last)
                cmd_reg.op <= OP_BYTE_LAST;
            else if (has_byte)
                cmd_reg.op <= OP_BYTE;
            else
                cmd_reg.op <= OP_LAST;
        end
    end

endmodule

>>> rtl/core/sha1md_queue.sv
// ----------------------------------------------------------------------------
// sha1md_queue
// Small command queue between the input stage and the hash engine.
// ----------------------------------------------------------------------------
module sha1md_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  sha1md_pkg::cmd_t           push_cmd,
    input  logic                       pop,
    output sha1md_pkg::cmd_t           pop_cmd,
    output sha1md_pkg::queue_status_t  status
);
    import sha1md_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/sha1md_engine.sv
// ----------------------------------------------------------------------------
// sha1md_engine
// Byte packing, padding, 80-round compression and digest word output.
// ----------------------------------------------------------------------------
module sha1md_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_avail,
    input  sha1md_pkg::cmd_t  cmd,
    output logic              cmd_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);
    import sha1md_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next;
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [60:0]  count_reg, count_next;
    logic [5:0]   pos_reg, pos_next;
    logic [6:0]   round_reg, round_next;
    logic [2:0]   len_idx_reg, len_idx_next;
    logic         pad_first_reg, pad_first_next;
    logic [2:0]   idx_reg, idx_next;

    logic [63:0]  bit_len;
    logic [7:0]   len_byte;
    logic [31:0]  w_new;
    logic [31:0]  t_sum;
    logic [5:0]   pos_inc;
    logic         out_xfer;

    assign bit_len  = {count_reg, 3'b000};
    assign len_byte = bit_len[63 - 8 * len_idx_reg -: 8];
    assign pos_inc  = pos_reg + 6'd1;
    assign w_new    = rotl(blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416]
                           ^ blk_reg[511:480], 1);
    assign t_sum    = rotl(a_reg, 5) + round_f(round_reg, b_reg, c_reg, d_reg) + e_reg
                      + round_k(round_reg) + blk_reg[511:480];
    assign out_valid = (state_reg == S_OUT);
    assign out_xfer  = out_valid && !out_stall;
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == WORD_LAST);

    always_comb
    begin
        case (idx_reg)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        blk_next       = blk_reg;
        chain_next     = chain_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        round_next     = round_reg;
        len_idx_next   = len_idx_reg;
        pad_first_next = pad_first_reg;
        idx_next       = idx_reg;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop        = 1'b1;
                    pad_first_next = 1'b1;
                    len_idx_next   = '0;
                    if (cmd.op == OP_LAST)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        blk_next   = {blk_reg[503:0], cmd.data};
                        pos_next   = pos_inc;
                        count_next = count_reg + 61'd1;
                        ret_next   = (cmd.op == OP_BYTE_LAST) ? S_PAD : S_IDLE;
                        if (pos_reg == POS_LAST)
                        begin
                            state_next = S_ROUND;
                            round_next = '0;
                            a_next     = chain_reg[0];
                            b_next     = chain_reg[1];
                            c_next     = chain_reg[2];
                            d_next     = chain_reg[3];
                            e_next     = chain_reg[4];
                        end
                        else if (cmd.op == OP_BYTE_LAST)
                        begin
                            state_next = S_PAD;
                        end
                    end
                end
            end
            S_PAD:
            begin
                blk_next       = {blk_reg[503:0], pad_first_reg ? PAD_MARK : PAD_ZERO};
                pad_first_next = 1'b0;
                pos_next       = pos_inc;
                if (pos_reg == POS_LAST)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_PAD;
                    round_next = '0;
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                    e_next     = chain_reg[4];
                end
                else if (pos_inc == POS_LEN)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                blk_next     = {blk_reg[503:0], len_byte};
                pos_next     = pos_inc;
                len_idx_next = len_idx_reg + 3'd1;
                if (pos_reg == POS_LAST)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_OUT;
                    round_next = '0;
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                    e_next     = chain_reg[4];
                end
            end
            S_ROUND:
            begin
                a_next     = t_sum;
                b_next     = a_reg;
                c_next     = rotl(b_reg, 30);
                d_next     = c_reg;
                e_next     = d_reg;
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                state_next    = ret_reg;
                idx_next      = '0;
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    if (idx_reg == WORD_LAST)
                    begin
                        chain_next[0] = H0;
                        chain_next[1] = H1;
                        chain_next[2] = H2;
                        chain_next[3] = H3;
                        chain_next[4] = H4;
                        count_next    = '0;
                        pos_next      = '0;
                        idx_next      = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            chain_reg[0]  <= H0;
            chain_reg[1]  <= H1;
            chain_reg[2]  <= H2;
            chain_reg[3]  <= H3;
            chain_reg[4]  <= H4;
            count_reg     <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            len_idx_reg   <= '0;
            pad_first_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            len_idx_reg   <= len_idx_next;
            pad_first_reg <= pad_first_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule

>>> rtl/core/sha1_message_digest_unit.sv
// Flow: each transfer is registered in the input stage and passes the queue;
// the engine then packs the message bytes, and each full 64-byte block runs
// 80 rounds plus the chain add. Finishing a message takes 9 to 72 padding and
// length bytes, one or two compressions, then five output transfers.
// Sustained rate is set by the one-round-per-cycle compression loop.
// Reset: chaining words return to the SHA-1 initial values, counters clear.
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 digest of a byte stream; emits five digest words per message.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1md_pkg::*;

    logic          front_valid;
    cmd_t          front_cmd;
    cmd_t          queue_cmd;
    queue_status_t queue_status;
    logic          engine_pop;

    sha1md_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .msg_byte  (msg_byte),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (!queue_status.full)
    );

    sha1md_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .push_cmd (front_cmd),
        .pop      (engine_pop),
        .pop_cmd  (queue_cmd),
        .status   (queue_status)
    );

    sha1md_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (!queue_status.empty),
        .cmd         (queue_cmd),
        .cmd_pop     (engine_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

>>> dv/tb_sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_unit
// Self-checking bench for the SHA-1 digest unit. Byte streams of many
// lengths, padding boundaries included, are fed with random idle gaps.
// A local SHA-1 model predicts the five digest words of every message,
// and each output transfer is checked against them in order.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_unit;

    import sha1md_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int RESET_CYC  = 4;
    localparam int LIMIT_CYC  = 200000;
    localparam int DRAIN_CYC  = 300;
    localparam int QUIET_FROM = 600;
    localparam int QUIET_TO   = 1400;
    localparam int HOLD_CYC   = 300;
    localparam int IDLE_PCT   = 23;
    localparam int BYTE_GOAL  = 230;
    localparam int DIRECTED   = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  msg_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    byte_item_t   byte_fifo[$];
    digest_word_t digest_fifo[$];
    byte_item_t   next_item;
    digest_word_t got_word;

    logic [31:0] chain_h[5];
    logic [31:0] block_w[16];
    logic [60:0] byte_total;

    int cyc = 0;
    int errors = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sha1_message_digest_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .msg_byte   (msg_byte),
        .has_byte   (has_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digest_word(digest_word),
        .word_index (word_index),
        .last_word  (last_word)
    );

    always #CLK_HALF clk = ~clk;

    function automatic bit idle_now();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic restart_digest();
        chain_h[0] = H0;
        chain_h[1] = H1;
        chain_h[2] = H2;
        chain_h[3] = H3;
        chain_h[4] = H4;
        byte_total = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = block_w[i];
        for (i = 16; i < 80; i++)
            w[i] = rotate_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotate_left(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    task automatic shift_in(input logic [7:0] b, inout logic [5:0] pos);
        block_w[pos[5:2]] = {block_w[pos[5:2]][23:0], b};
        pos = pos + 6'd1;
        if (pos == 6'd0)
            compress_block();
    endtask

    // digest model, advanced once per input transfer
    task automatic absorb_transfer(input logic [7:0] b, input logic has, input logic fin);
        logic [5:0]   pos;
        logic [63:0]  bit_len;
        digest_word_t dw;
        int i;
        if (has)
        begin
            pos = byte_total[5:0];
            shift_in(b, pos);
            byte_total = byte_total + 61'd1;
        end
        if (fin)
        begin
            bit_len = {byte_total, 3'b000};
            pos = byte_total[5:0];
            shift_in(PAD_MARK, pos);
            while (pos != POS_LEN)
                shift_in(PAD_ZERO, pos);
            for (i = 0; i < 8; i++)
                shift_in(bit_len[63 - 8*i -: 8], pos);
            for (i = 0; i < 5; i++)
            begin
                dw.word = chain_h[i];
                dw.idx  = 3'(i);
                dw.fin  = (3'(i) == WORD_LAST);
                digest_fifo.insert(digest_fifo.size(), dw);
            end
            restart_digest();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("[%0t] mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    task automatic push_item(input logic [7:0] b, input logic has, input logic fin);
        byte_item_t it;
        it.data = b;
        it.has  = has;
        it.fin  = fin;
        byte_fifo.insert(byte_fifo.size(), it);
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            msg_byte <= 8'h00;
            has_byte <= 1'b0;
            is_last  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_transfer(msg_byte, has_byte, is_last);
            if (!in_valid || !in_stall)
            begin
                if (byte_fifo.size() != 0 && !idle_now())
                begin
                    next_item = byte_fifo.pop_front();
                    in_valid <= 1'b1;
                    msg_byte <= next_item.data;
                    has_byte <= next_item.has;
                    is_last  <= next_item.fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: random stalls plus one long hold while input is still busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left == 1) ? idle_now() : 1'b1;
        end
        else if (!hold_done && out_valid && cyc > 300 && byte_fifo.size() > 20)
        begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_now();
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_fifo.size() == 0)
                report_mismatch("unexpected transfer", 32'h0, digest_word);
            else
            begin
                got_word = digest_fifo.pop_front();
                if (digest_word !== got_word.word)
                    report_mismatch("digest_word", got_word.word, digest_word);
                if (word_index !== got_word.idx)
                    report_mismatch("word_index", 32'(got_word.idx), 32'(word_index));
                if (last_word !== got_word.fin)
                    report_mismatch("last_word", 32'(got_word.fin), 32'(last_word));
            end
        end
    end

    initial
    begin
        int pad_edges[6];
        int len, n_bytes, j, pick;
        pad_edges = '{55, 56, 57, 63, 64, 65};
        foreach (block_w[i])
            block_w[i] = '0;
        restart_digest();

        // directed: empty message, idle, "abc", single extreme bytes, empty tail
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1);
        n_bytes = DIRECTED;

        while (n_bytes < BYTE_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                len = $urandom_range(0, 8);
            else if (pick < 8)
                len = pad_edges[$urandom_range(0, 5)];
            else
                len = $urandom_range(0, 130);
            if (len > BYTE_GOAL - n_bytes)
                len = BYTE_GOAL - n_bytes;
            pick = $urandom_range(0, 1);
            for (j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 99) < 6)
                begin
                    push_item(8'($urandom), 1'b0, 1'b0);
                    n_bytes++;
                end
                push_item(8'($urandom), 1'b1, (j == len - 1) && pick == 1);
                n_bytes++;
            end
            if (len == 0 || pick == 0)
            begin
                push_item(8'($urandom), 1'b0, 1'b1);
                n_bytes++;
            end
        end

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_fifo.size() != 0 || in_valid)
            @(posedge clk);
        while (digest_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
